[sv/srisc_pkg.sv]
package srisc_pkg;

    localparam int DMEM_DEPTH = 4096;
    localparam int DMEM_AW    = $clog2(DMEM_DEPTH);
    localparam int REG_COUNT  = 16;
    localparam int REG_AW     = $clog2(REG_COUNT);
    localparam int IO_COUNT   = 23;
    localparam int XLEN       = 32;
    localparam int PC_W       = 12;
    localparam int PLEN_W     = 13;

    typedef enum logic [7:0] {
        OP_ADD  = 8'd0,
        OP_SUB  = 8'd1,
        OP_AND  = 8'd2,
        OP_OR   = 8'd3,
        OP_SLL  = 8'd4,
        OP_SRA  = 8'd5,
        OP_SRL  = 8'd6,
        OP_BEQ  = 8'd7,
        OP_BNE  = 8'd8,
        OP_BLT  = 8'd9,
        OP_BGT  = 8'd10,
        OP_BLE  = 8'd11,
        OP_BGE  = 8'd12,
        OP_JAL  = 8'd13,
        OP_LW   = 8'd14,
        OP_SW   = 8'd15,
        OP_RETI = 8'd16,
        OP_IN   = 8'd17,
        OP_OUT  = 8'd18,
        OP_HALT = 8'd19
    } t_op;

    typedef enum logic [1:0] {
        FLT_NONE = 2'd0,
        FLT_OP   = 2'd1,
        FLT_MEM  = 2'd2,
        FLT_IO   = 2'd3
    } t_fault;

    // io register map
    localparam logic [4:0] IO_IRQ0EN   = 5'd0;
    localparam logic [4:0] IO_IRQ1EN   = 5'd1;
    localparam logic [4:0] IO_IRQ2EN   = 5'd2;
    localparam logic [4:0] IO_IRQ0ST   = 5'd3;
    localparam logic [4:0] IO_IRQ1ST   = 5'd4;
    localparam logic [4:0] IO_IRQ2ST   = 5'd5;
    localparam logic [4:0] IO_HANDLER  = 5'd6;
    localparam logic [4:0] IO_RETURN   = 5'd7;
    localparam logic [4:0] IO_CLKS     = 5'd8;
    localparam logic [4:0] IO_TIMEREN  = 5'd11;
    localparam logic [4:0] IO_TIMERCUR = 5'd12;
    localparam logic [4:0] IO_TIMERMAX = 5'd13;

    typedef struct packed {
        logic [7:0]         opcode;
        logic [3:0]         dest_reg;
        logic [3:0]         src_a_reg;
        logic [3:0]         src_b_reg;
        logic signed [11:0] immediate_one;
        logic signed [11:0] immediate_two;
        logic               external_irq;
    } t_in;

    typedef struct packed {
        logic [11:0] next_pc;
        logic        halted;
        logic [1:0]  fault;
        logic        io_write_valid;
        logic [4:0]  io_write_index;
        logic [31:0] io_write_value;
        logic        irq_taken;
    } t_out;

    function automatic logic [31:0] io_in_mask(input logic [4:0] idx);
        logic [31:0] m;
        case (idx)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd11, 5'd17: m = 32'h0000_0001;
            5'd6, 5'd7, 5'd16:                                m = 32'h0000_0FFF;
            5'd8, 5'd9, 5'd10, 5'd12, 5'd13:                  m = 32'hFFFF_FFFF;
            5'd14:                                            m = 32'h0000_0003;
            5'd15:                                            m = 32'h0000_007F;
            5'd20:                                            m = 32'h0000_FFFF;
            5'd21:                                            m = 32'h0000_00FF;
            default:                                          m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] io_out_mask(input logic [4:0] idx);
        logic [31:0] m;
        m = (idx == 5'd22) ? 32'h0000_0001 : io_in_mask(idx);
        return m;
    endfunction

endpackage

[sv/srisc_ram.sv]
module srisc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

[sv/srisc_alu.sv]
module srisc_alu
    import srisc_pkg::*;
(
    input  t_op         i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_res,
    output logic        o_cond
);

    logic       big_shift;
    logic [4:0] sra_amt;

    assign big_shift = |i_b[31:5];
    assign sra_amt   = big_shift ? 5'd31 : i_b[4:0];

    always_comb begin
        o_res  = '0;
        o_cond = 1'b0;
        unique case (i_op)
            OP_ADD:  o_res = i_a + i_b;
            OP_SUB:  o_res = i_a - i_b;
            OP_AND:  o_res = i_a & i_b;
            OP_OR:   o_res = i_a | i_b;
            OP_SLL:  o_res = big_shift ? '0 : i_a << i_b[4:0];
            OP_SRA:  o_res = $unsigned($signed(i_a) >>> sra_amt);
            OP_SRL:  o_res = big_shift ? '0 : i_a >> i_b[4:0];
            OP_BEQ:  o_cond = (i_a == i_b);
            OP_BNE:  o_cond = (i_a != i_b);
            OP_BLT:  o_cond = ($signed(i_a) <  $signed(i_b));
            OP_BGT:  o_cond = ($signed(i_a) >  $signed(i_b));
            OP_BLE:  o_cond = ($signed(i_a) <= $signed(i_b));
            OP_BGE:  o_cond = ($signed(i_a) >= $signed(i_b));
            default: o_res = '0;
        endcase
    end

endmodule

[sv/simple_risc_core_with_interrupts.sv]
// simple risc core with interrupts
//
// input channel (i_in_valid / o_in_stall): one word per instruction, the
// instruction fetched at the last reported next_pc plus an external irq pulse.
// output channel (o_out_valid / i_out_stall): one result word per instruction
// with next pc, halted, fault code, io write report and irq taken flag.
// config channel (i_cfg_valid / o_cfg_ready): program length, always ready.
//
// a word is taken into the execute slot and its result is registered in the
// output register when it finishes; a load first issues the synchronous data
// memory read. other instructions run at one word per cycle unless stalled.
// the register file sits in three copies of a 16 entry ram (one read port per
// operand) with a one entry bypass that holds the latest register write.
//
// after reset the data memory is swept to zero, one entry a cycle, over all
// DMEM_DEPTH entries (4096); the input stalls until the sweep ends.
// when the receiver stalls, the result word holds in the output register and
// the core keeps one further instruction in execute, then stalls its input.
module simple_risc_core_with_interrupts
    import srisc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);

    // register read with the fixed registers and the bypass folded in
    function automatic logic [31:0] rf_val(
        input logic [3:0]  idx,
        input logic [31:0] q,
        input logic [11:0] imm1,
        input logic [11:0] imm2,
        input logic        byp_vld,
        input logic [3:0]  byp_idx,
        input logic [31:0] byp_data,
        input logic        ent_vld
    );
        logic [31:0] v;
        if (idx == 4'd0) begin
            v = '0;
        end else if (idx == 4'd1) begin
            v = {{20{imm1[11]}}, imm1};
        end else if (idx == 4'd2) begin
            v = {{20{imm2[11]}}, imm2};
        end else if (byp_vld && byp_idx == idx) begin
            v = byp_data;
        end else begin
            v = ent_vld ? q : '0;
        end
        return v;
    endfunction

    // execute slot
    logic               r_e_vld;
    t_in                r_e;
    logic               r_ld_ph;
    // architectural state outside the rams
    logic [PC_W-1:0]    r_pc;
    logic               r_stopped;
    logic               r_in_hdl;
    logic [PLEN_W-1:0]  r_plen;
    logic [31:0]        r_io [IO_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic               r_byp_vld;
    logic [REG_AW-1:0]  r_byp_idx;
    logic [31:0]        r_byp_data;
    // memory clear sweep
    logic               r_clr;
    logic [DMEM_AW-1:0] r_clr_cnt;
    // output register
    logic               r_out_vld;
    t_out               r_out;

    logic [31:0]        q_a, q_b, q_d, q_m;
    logic [31:0]        a, b, d;
    logic [31:0]        alu_res;
    logic               alu_cond;
    t_op                op;
    logic               acc, run, dead, fin, ld_start;
    logic signed [32:0] addr;
    logic               mem_ok, io_ok;
    logic [4:0]         ioi;

    logic [PC_W-1:0]    n_pc;
    logic               n_stopped;
    logic               n_in_hdl;
    logic [31:0]        n_io [IO_COUNT];
    t_out               n_res;
    logic               rf_we;
    logic [REG_AW-1:0]  rf_wa;
    logic [31:0]        rf_wd;
    logic               dm_we;
    logic               dm_we_x;
    logic [DMEM_AW-1:0] dm_wa;
    logic [31:0]        dm_wd;

    assign op  = t_op'(r_e.opcode);
    assign acc = i_in_valid && !o_in_stall;

    // operand reads issued on the edge that takes the word
    srisc_ram #(.DEPTH(REG_COUNT), .WIDTH(32)) u_rf_a (
        .i_clk(i_clk), .i_we(rf_we && fin), .i_waddr(rf_wa), .i_wdata(rf_wd),
        .i_re(acc), .i_raddr(i_in.src_a_reg), .o_rdata(q_a)
    );
    srisc_ram #(.DEPTH(REG_COUNT), .WIDTH(32)) u_rf_b (
        .i_clk(i_clk), .i_we(rf_we && fin), .i_waddr(rf_wa), .i_wdata(rf_wd),
        .i_re(acc), .i_raddr(i_in.src_b_reg), .o_rdata(q_b)
    );
    srisc_ram #(.DEPTH(REG_COUNT), .WIDTH(32)) u_rf_d (
        .i_clk(i_clk), .i_we(rf_we && fin), .i_waddr(rf_wa), .i_wdata(rf_wd),
        .i_re(acc), .i_raddr(i_in.dest_reg), .o_rdata(q_d)
    );

    // data memory: sweep port during clear, store port otherwise
    assign dm_we = r_clr || (dm_we_x && fin);
    assign dm_wa = r_clr ? r_clr_cnt : addr[DMEM_AW-1:0];
    assign dm_wd = r_clr ? '0 : d;

    srisc_ram #(.DEPTH(DMEM_DEPTH), .WIDTH(32)) u_dmem (
        .i_clk(i_clk), .i_we(dm_we), .i_waddr(dm_wa), .i_wdata(dm_wd),
        .i_re(ld_start), .i_raddr(addr[DMEM_AW-1:0]), .o_rdata(q_m)
    );

    assign a = rf_val(r_e.src_a_reg, q_a, r_e.immediate_one, r_e.immediate_two,
                      r_byp_vld, r_byp_idx, r_byp_data, r_rf_vld[r_e.src_a_reg]);
    assign b = rf_val(r_e.src_b_reg, q_b, r_e.immediate_one, r_e.immediate_two,
                      r_byp_vld, r_byp_idx, r_byp_data, r_rf_vld[r_e.src_b_reg]);
    assign d = rf_val(r_e.dest_reg, q_d, r_e.immediate_one, r_e.immediate_two,
                      r_byp_vld, r_byp_idx, r_byp_data, r_rf_vld[r_e.dest_reg]);

    srisc_alu u_alu (
        .i_op(op), .i_a(a), .i_b(b), .o_res(alu_res), .o_cond(alu_cond)
    );

    assign addr   = $signed({a[31], a}) + $signed({b[31], b});
    assign mem_ok = (addr >= 33'sd0) && (addr < $signed(33'(DMEM_DEPTH)));
    assign io_ok  = (addr >= 33'sd0) && (addr < $signed(33'(IO_COUNT)));
    assign ioi    = addr[4:0];

    assign run  = r_e_vld && !r_clr;
    assign dead = r_stopped || ({1'b0, r_pc} >= r_plen);
    // an in-range load first issues the data memory read, then finishes
    assign ld_start = run && !dead && (op == OP_LW) && mem_ok && !r_ld_ph;
    assign fin  = run && !ld_start && (!r_out_vld || !i_out_stall);

    assign o_in_stall  = r_clr || (r_e_vld && !fin);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // execute and commit values
    always_comb begin
        logic [PLEN_W-1:0] npc;
        logic              halt_now;
        logic              irq0, irq1, irq2;
        logic [1:0]        flt;
        logic              wv;
        logic [4:0]        widx;
        logic [31:0]       wval;
        logic              taken;

        npc       = {1'b0, r_pc} + 1'b1;
        halt_now  = 1'b0;
        irq0      = 1'b0;
        irq1      = 1'b0;
        irq2      = 1'b0;
        flt       = FLT_NONE;
        wv        = 1'b0;
        widx      = '0;
        wval      = '0;
        taken     = 1'b0;
        n_pc      = r_pc;
        n_stopped = r_stopped;
        n_in_hdl  = r_in_hdl;
        n_io      = r_io;
        rf_we     = 1'b0;
        rf_wa     = r_e.dest_reg;
        rf_wd     = alu_res;
        dm_we_x   = 1'b0;
        n_res     = '0;

        if (dead) begin
            n_stopped     = 1'b1;
            n_res.next_pc = r_pc;
            n_res.halted  = 1'b1;
        end else begin
            unique case (op)
                OP_ADD, OP_SUB, OP_AND, OP_OR, OP_SLL, OP_SRA, OP_SRL: begin
                    rf_we = 1'b1;
                end
                OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_BLE, OP_BGE: begin
                    if (alu_cond) begin
                        npc = {1'b0, d[PC_W-1:0]};
                    end
                end
                OP_JAL: begin
                    // link is written before the target register is read
                    rf_we = 1'b1;
                    rf_wa = 4'd15;
                    rf_wd = {{(32-PLEN_W){1'b0}}, npc};
                    if (r_e.dest_reg != 4'd15) begin
                        npc = {1'b0, d[PC_W-1:0]};
                    end else begin
                        // target is the link value cut to 12 bits
                        npc = {1'b0, npc[PC_W-1:0]};
                    end
                end
                OP_LW: begin
                    if (!mem_ok) begin
                        flt = FLT_MEM;
                    end else begin
                        rf_we = 1'b1;
                        rf_wd = q_m;
                    end
                end
                OP_SW: begin
                    if (!mem_ok) begin
                        flt = FLT_MEM;
                    end else begin
                        dm_we_x = 1'b1;
                    end
                end
                OP_RETI: begin
                    npc      = {1'b0, r_io[IO_RETURN][PC_W-1:0]};
                    n_in_hdl = 1'b0;
                end
                OP_IN: begin
                    if (!io_ok) begin
                        flt = FLT_IO;
                    end else begin
                        rf_we = 1'b1;
                        rf_wd = r_io[ioi] & io_in_mask(ioi);
                    end
                end
                OP_OUT: begin
                    if (!io_ok) begin
                        flt = FLT_IO;
                    end else begin
                        wv        = 1'b1;
                        widx      = ioi;
                        wval      = d & io_out_mask(ioi);
                        n_io[ioi] = wval;
                    end
                end
                OP_HALT: begin
                    halt_now = 1'b1;
                end
                default: begin
                    flt = FLT_OP;
                end
            endcase
            // registers 0..2 are never written by instructions
            if (rf_wa <= 4'd2) begin
                rf_we = 1'b0;
            end

            n_io[IO_CLKS] = n_io[IO_CLKS] + 32'd1;

            if (halt_now) begin
                n_stopped     = 1'b1;
                n_res.next_pc = r_pc;
            end else if (npc >= r_plen) begin
                n_stopped     = 1'b1;
                n_pc          = npc[PC_W-1:0];
                n_res.next_pc = n_pc;
            end else begin
                n_pc = npc[PC_W-1:0];
                irq0 = n_io[IO_IRQ0EN][0] & n_io[IO_IRQ0ST][0];
                if (n_io[IO_TIMEREN] != '0) begin
                    if (n_io[IO_TIMERCUR] < n_io[IO_TIMERMAX]) begin
                        n_io[IO_TIMERCUR] = n_io[IO_TIMERCUR] + 32'd1;
                    end else begin
                        n_io[IO_TIMERCUR] = '0;
                        n_io[IO_IRQ0ST]   = 32'd1;
                    end
                end
                irq1 = n_io[IO_IRQ1EN][0] & n_io[IO_IRQ1ST][0];
                if (r_e.external_irq) begin
                    n_io[IO_IRQ2ST] = 32'd1;
                end
                irq2 = n_io[IO_IRQ2EN][0] & n_io[IO_IRQ2ST][0];
                if ((irq0 || irq1 || irq2) && !n_in_hdl) begin
                    n_in_hdl        = 1'b1;
                    n_io[IO_RETURN] = {{(32-PC_W){1'b0}}, n_pc};
                    n_pc            = n_io[IO_HANDLER][PC_W-1:0];
                    taken           = 1'b1;
                end
                n_res.next_pc = n_pc;
            end
            n_res.halted         = n_stopped;
            n_res.fault          = flt;
            n_res.io_write_valid = wv;
            n_res.io_write_index = widx;
            n_res.io_write_value = wval;
            n_res.irq_taken      = taken;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld   <= 1'b0;
            r_ld_ph   <= 1'b0;
            r_pc      <= '0;
            r_stopped <= 1'b0;
            r_in_hdl  <= 1'b0;
            r_plen    <= PLEN_W'(4096);
            r_io      <= '{default: '0};
            r_rf_vld  <= '0;
            r_byp_vld <= 1'b0;
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_plen <= i_cfg_data;
            end
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == DMEM_AW'(DMEM_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (ld_start) begin
                r_ld_ph <= 1'b1;
            end
            if (fin) begin
                r_ld_ph   <= 1'b0;
                r_pc      <= n_pc;
                r_stopped <= n_stopped;
                r_in_hdl  <= n_in_hdl;
                r_io      <= n_io;
                r_out_vld <= 1'b1;
                if (rf_we) begin
                    r_rf_vld[rf_wa] <= 1'b1;
                    r_byp_vld       <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (acc) begin
                r_e_vld <= 1'b1;
            end else if (fin) begin
                r_e_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_e <= i_in;
        end
        if (fin) begin
            r_out <= n_res;
            if (rf_we) begin
                r_byp_idx  <= rf_wa;
                r_byp_data <= rf_wd;
            end
        end
    end

endmodule

[sv/srisc_chk.sv]
module srisc_chk
    import srisc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result word changed");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word shown right after reset");

    a_halt_no_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.halted |-> !o_out.irq_taken)
        else $error("interrupt taken on a halted step");

    a_io_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.io_write_valid |->
            o_out.io_write_index == 5'd0 && o_out.io_write_value == 32'd0)
        else $error("io write fields set without io write");

    a_fault_no_io: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.fault != FLT_NONE |-> !o_out.io_write_valid)
        else $error("io write reported on a faulting step");

endmodule

bind simple_risc_core_with_interrupts srisc_chk u_srisc_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out(o_out)
);
